FILE: rtl/core/bpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the buddy page allocator: page node layout,
// list head layout, memory request bundles, status and command codes.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int NUM_PAGES   = 65536;
    localparam int MAX_ORDER   = 15;
    localparam int TAG_COUNT   = 16;
    localparam int DUMMY_TAG   = TAG_COUNT - 1;
    localparam int ORDER_SLOTS = MAX_ORDER + 1;

    localparam int PFN_W  = 16;
    localparam int ORD_W  = 4;
    localparam int TAG_W  = 4;
    localparam int HEAD_W = TAG_W + ORD_W;
    localparam int CNT_W  = 17;

    localparam logic [CNT_W-1:0] COUNT_MAX = 17'h1FFFF;

    // command codes
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_ADD   = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOSPACE = 2'd1,
        STAT_BAD     = 2'd2
    } t_status;

    // one node per page
    typedef struct packed {
        logic [ORD_W-1:0] order;
        logic [TAG_W-1:0] tag;
        logic             alloc;
        logic             avail;
        logic             linked;
        logic [PFN_W-1:0] next;
    } t_node;

    // free list head per tag and order
    typedef struct packed {
        logic             has;
        logic [PFN_W-1:0] first;
    } t_head;

    typedef struct packed {
        logic             re;
        logic [PFN_W-1:0] raddr;
        logic             we;
        logic [PFN_W-1:0] waddr;
    } t_node_req;

    typedef struct packed {
        logic              re;
        logic [HEAD_W-1:0] raddr;
        logic              we;
        logic [HEAD_W-1:0] waddr;
    } t_head_req;

    localparam t_node NODE_RESET = '{
        order:  4'd0,
        tag:    4'(DUMMY_TAG),
        alloc:  1'b0,
        avail:  1'b0,
        linked: 1'b0,
        next:   16'd0
    };

endpackage

FILE: rtl/core/bpa_node_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_node_mem
// Per-page node store: one write port, one read port, registered read data
// with write-to-read forwarding on an address match.
// ----------------------------------------------------------------------------
module bpa_node_mem (
    input  logic               i_clk,
    input  bpa_pkg::t_node_req i_req,
    input  bpa_pkg::t_node     i_wdata,
    output bpa_pkg::t_node     o_rdata
);
    import bpa_pkg::*;

    t_node r_mem [0:NUM_PAGES-1];
    t_node r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            if (i_req.we && (i_req.waddr == i_req.raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_req.raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/bpa_head_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_head_mem
// Free list heads per tag and order. The first page sits in a memory; the
// non-empty bit of each list sits in flops so reset empties every list.
// ----------------------------------------------------------------------------
module bpa_head_mem (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bpa_pkg::t_head_req                  i_req,
    input  bpa_pkg::t_head                      i_wdata,
    output bpa_pkg::t_head                      o_rdata,
    input  logic [bpa_pkg::TAG_W-1:0]           i_row_tag,
    output logic [bpa_pkg::ORDER_SLOTS-1:0]     o_has_row
);
    import bpa_pkg::*;

    localparam int HEAD_DEPTH = TAG_COUNT * ORDER_SLOTS;

    logic [HEAD_DEPTH-1:0] r_has;
    logic [PFN_W-1:0]      r_first [0:HEAD_DEPTH-1];
    t_head                 r_rdata;

    // list non-empty bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has <= '0;
        end else if (i_req.we) begin
            r_has[i_req.waddr] <= i_wdata.has;
        end
    end

    // first page store
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_first[i_req.waddr] <= i_wdata.first;
        end
    end

    // registered read with forwarding
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            if (i_req.we && (i_req.waddr == i_req.raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata.has   <= r_has[i_req.raddr];
                r_rdata.first <= r_first[i_req.raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

    // non-empty bits of all orders of one tag
    always_comb begin
        for (int o = 0; o < ORDER_SLOTS; o++) begin
            o_has_row[o] = r_has[{i_row_tag, ORD_W'(o)}];
        end
    end

endmodule

FILE: rtl/core/buddy_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Tagged buddy page allocator with LIFO free lists linked through a per-page
// node memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps the node memory once, one page a cycle, and
// takes no command until the sweep is done. It then works on one command
// at a time, each node or list head access going through the single read
// port of each memory. Allocate splits a larger block down as needed. Free
// merges with the buddy as far as it can, walking the free list to unlink
// the buddy and the block. Add region carves the range into aligned blocks.
// The result of one command may sit in the output register while the next
// command is taken.
// ----------------------------------------------------------------------------
module buddy_page_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_page_request,
    input  logic [15:0] i_frame_number,
    input  logic [16:0] i_region_pages,
    input  logic [3:0]  i_zone_tag,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_block_frame,
    output logic [15:0] o_block_pages
);
    import bpa_pkg::*;

    typedef enum logic [25:0] {
        S_CLR      = 26'h0000001,
        S_IDLE     = 26'h0000002,
        S_DEC      = 26'h0000004,
        S_SP_RH    = 26'h0000008,
        S_SP_RN    = 26'h0000010,
        S_SP_WP    = 26'h0000020,
        S_SP_WQ    = 26'h0000040,
        S_PO_RH    = 26'h0000080,
        S_PO_RN    = 26'h0000100,
        S_PO_WR    = 26'h0000200,
        S_FR_CHK   = 26'h0000400,
        S_FR_PUSH  = 26'h0000800,
        S_MG_CHK   = 26'h0001000,
        S_MG_CMP   = 26'h0002000,
        S_UL_HD    = 26'h0004000,
        S_UL_FIRST = 26'h0008000,
        S_UL_POP   = 26'h0010000,
        S_UL_RD    = 26'h0020000,
        S_UL_CHK   = 26'h0040000,
        S_UL_LNK   = 26'h0080000,
        S_UL_CLR   = 26'h0100000,
        S_MS_RH    = 26'h0200000,
        S_MS_WR    = 26'h0400000,
        S_AD_RH    = 26'h0800000,
        S_AD_WR    = 26'h1000000,
        S_FIN      = 26'h2000000
    } t_state;

    // highest set bit position plus one
    function automatic logic [4:0] f_bitlen(input logic [16:0] v);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 0; i < 17; i++) begin
            if (v[i]) r = 5'(i + 1);
        end
        return r;
    endfunction

    // trailing zero count, 16 for zero
    function automatic logic [4:0] f_tz(input logic [15:0] v);
        logic [4:0] r;
        r = 5'd16;
        for (int i = 15; i >= 0; i--) begin
            if (v[i]) r = 5'(i);
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] f_sat_add(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? COUNT_MAX : s[CNT_W-1:0];
    endfunction

    // fresh free block node
    function automatic t_node f_block(input logic [ORD_W-1:0] ord,
                                      input logic [TAG_W-1:0] tag,
                                      input logic has,
                                      input logic [PFN_W-1:0] nxt);
        t_node n;
        n.order  = ord;
        n.tag    = tag;
        n.alloc  = 1'b0;
        n.avail  = 1'b1;
        n.linked = has;
        n.next   = has ? nxt : '0;
        return n;
    endfunction

    // control registers
    t_state           r_state, n_state;
    logic [PFN_W-1:0] r_clr, n_clr;
    logic             r_out_valid, n_out_valid;
    logic [CNT_W-1:0] r_count [0:TAG_COUNT-1];
    logic [CNT_W-1:0] n_count [0:TAG_COUNT-1];

    // working registers
    logic [1:0]       r_cmd, n_cmd;
    logic [15:0]      r_req, n_req;
    logic [PFN_W-1:0] r_frame, n_frame;
    logic [16:0]      r_len, n_len;
    logic [TAG_W-1:0] r_tag, n_tag;
    logic [ORD_W-1:0] r_ord, n_ord;
    logic [ORD_W-1:0] r_k, n_k;
    logic [PFN_W-1:0] r_pfn, n_pfn;
    logic [PFN_W-1:0] r_other, n_other;
    logic [PFN_W-1:0] r_p, n_p;
    logic [PFN_W-1:0] r_ul_target, n_ul_target;
    logic             r_ul_second, n_ul_second;
    logic [PFN_W-1:0] r_prev, n_prev;
    t_node            r_prev_node, n_prev_node;
    logic [16:0]      r_steps, n_steps;
    logic [16:0]      r_cur, n_cur;
    logic [16:0]      r_rem, n_rem;
    t_status          r_status, n_status;
    logic [15:0]      r_res_frame, n_res_frame;
    logic [15:0]      r_res_pages, n_res_pages;
    t_status          r_out_status, n_out_status;
    logic [15:0]      r_out_frame, n_out_frame;
    logic [15:0]      r_out_pages, n_out_pages;

    // memory interface
    t_node_req        w_node_req;
    t_node            w_node_wdata;
    t_node            w_nd;
    t_head_req        w_head_req;
    t_head            w_head_wdata;
    t_head            w_hd;
    logic [ORDER_SLOTS-1:0] w_has_row;

    // derived values
    logic [15:0]      w_req_m1;
    logic [4:0]       w_aord;
    logic [CNT_W-1:0] w_asize;
    logic             w_found;
    logic [ORD_W-1:0] w_j;
    logic [CNT_W-1:0] w_size;
    logic [CNT_W-1:0] w_mask;
    logic [16:0]      w_other;
    logic [PFN_W-1:0] w_lo_pfn;
    logic [PFN_W-1:0] w_hi_pfn;
    logic [PFN_W-1:0] w_half;
    logic [17:0]      w_end;
    logic [4:0]       w_tz;
    logic [4:0]       w_fl;
    logic [ORD_W-1:0] w_bord;

    bpa_node_mem u_node_mem (
        .i_clk   (i_clk),
        .i_req   (w_node_req),
        .i_wdata (w_node_wdata),
        .o_rdata (w_nd)
    );

    bpa_head_mem u_head_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_head_req),
        .i_wdata   (w_head_wdata),
        .o_rdata   (w_hd),
        .i_row_tag (r_tag),
        .o_has_row (w_has_row)
    );

    // allocate: order of the request and first non-empty list at or above it
    assign w_req_m1 = r_req - 16'd1;
    assign w_aord   = (r_req == 16'd0) ? 5'd0 : f_bitlen({1'b0, w_req_m1});
    assign w_asize  = CNT_W'(1) << w_aord[ORD_W-1:0];

    always_comb begin
        w_found = 1'b0;
        w_j     = '0;
        for (int o = ORDER_SLOTS - 1; o >= 0; o--) begin
            if (w_has_row[o] && (5'(o) >= w_aord)) begin
                w_found = 1'b1;
                w_j     = ORD_W'(o);
            end
        end
    end

    // block size, buddy and split half
    assign w_size   = CNT_W'(1) << r_ord;
    assign w_mask   = (w_size << 1) - CNT_W'(1);
    assign w_other  = ((CNT_W'(r_pfn) & w_mask) == '0) ? CNT_W'(r_pfn) + w_size
                                                     : CNT_W'(r_pfn) - w_size;
    assign w_lo_pfn = (r_other < r_pfn) ? r_other : r_pfn;
    assign w_hi_pfn = (r_other < r_pfn) ? r_pfn : r_other;
    assign w_half   = PFN_W'(1) << (r_k - ORD_W'(1));

    // add region: largest aligned block that fits
    assign w_end  = 18'(r_frame) + 18'(r_len);
    assign w_tz   = f_tz(r_cur[PFN_W-1:0]);
    assign w_fl   = f_bitlen(r_rem) - 5'd1;
    always_comb begin
        logic [4:0] m;
        m = (w_tz < w_fl) ? w_tz : w_fl;
        w_bord = (m > 5'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : m[ORD_W-1:0];
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_out_valid  = r_out_valid && i_stall;
        n_count      = r_count;
        n_cmd        = r_cmd;
        n_req        = r_req;
        n_frame      = r_frame;
        n_len        = r_len;
        n_tag        = r_tag;
        n_ord        = r_ord;
        n_k          = r_k;
        n_pfn        = r_pfn;
        n_other      = r_other;
        n_p          = r_p;
        n_ul_target  = r_ul_target;
        n_ul_second  = r_ul_second;
        n_prev       = r_prev;
        n_prev_node  = r_prev_node;
        n_steps      = r_steps;
        n_cur        = r_cur;
        n_rem        = r_rem;
        n_status     = r_status;
        n_res_frame  = r_res_frame;
        n_res_pages  = r_res_pages;
        n_out_status = r_out_status;
        n_out_frame  = r_out_frame;
        n_out_pages  = r_out_pages;
        w_node_req   = '0;
        w_node_wdata = w_nd;
        w_head_req   = '0;
        w_head_wdata = w_hd;

        case (r_state)
            // node memory sweep after reset
            S_CLR: begin
                w_node_req.we    = 1'b1;
                w_node_req.waddr = r_clr;
                w_node_wdata     = NODE_RESET;
                n_clr            = r_clr + PFN_W'(1);
                if (r_clr == '1) n_state = S_IDLE;
            end

            S_IDLE: begin
                if (i_valid) begin
                    n_cmd       = i_command;
                    n_req       = i_page_request;
                    n_frame     = i_frame_number;
                    n_len       = i_region_pages;
                    n_tag       = i_zone_tag;
                    n_status    = STAT_OK;
                    n_res_frame = '0;
                    n_res_pages = '0;
                    n_state     = S_DEC;
                end
            end

            S_DEC: begin
                w_node_req.re    = 1'b1;
                w_node_req.raddr = r_frame;
                n_state          = S_FIN;
                case (r_cmd)
                    CMD_ALLOC: begin
                        if (r_tag >= TAG_W'(DUMMY_TAG) || w_aord > 5'(MAX_ORDER)) begin
                            n_status = STAT_BAD;
                        end else if (r_count[r_tag] < w_asize ||
                                     w_aord == 5'(MAX_ORDER) || !w_found) begin
                            n_status = STAT_NOSPACE;
                        end else begin
                            n_ord   = w_aord[ORD_W-1:0];
                            n_k     = w_j;
                            n_state = (w_j == w_aord[ORD_W-1:0]) ? S_PO_RH : S_SP_RH;
                        end
                    end
                    CMD_FREE: begin
                        n_state = S_FR_CHK;
                    end
                    CMD_ADD: begin
                        if (r_tag >= TAG_W'(DUMMY_TAG) || w_end > 18'(NUM_PAGES)) begin
                            n_status = STAT_BAD;
                        end else begin
                            n_count[r_tag] = f_sat_add(r_count[r_tag], r_len);
                            n_cur          = 17'(r_frame);
                            n_rem          = r_len;
                            n_state        = S_AD_RH;
                        end
                    end
                    default: begin
                        n_status = STAT_BAD;
                    end
                endcase
            end

            // split: pop order k, push both halves onto order k-1
            S_SP_RH: begin
                w_head_req.re    = 1'b1;
                w_head_req.raddr = {r_tag, r_k};
                n_state          = S_SP_RN;
            end
            S_SP_RN: begin
                n_p              = w_hd.first;
                w_node_req.re    = 1'b1;
                w_node_req.raddr = w_hd.first;
                w_head_req.re    = 1'b1;
                w_head_req.raddr = {r_tag, r_k - ORD_W'(1)};
                n_state          = S_SP_WP;
            end
            S_SP_WP: begin
                w_head_req.we       = 1'b1;
                w_head_req.waddr    = {r_tag, r_k};
                w_head_wdata.has    = w_nd.linked;
                w_head_wdata.first  = w_nd.linked ? w_nd.next : '0;
                w_node_req.we       = 1'b1;
                w_node_req.waddr    = r_p;
                w_node_wdata        = f_block(r_k - ORD_W'(1), r_tag, w_hd.has, w_hd.first);
                n_state             = S_SP_WQ;
            end
            S_SP_WQ: begin
                w_node_req.we      = 1'b1;
                w_node_req.waddr   = r_p + w_half;
                w_node_wdata       = f_block(r_k - ORD_W'(1), r_tag, 1'b1, r_p);
                w_head_req.we      = 1'b1;
                w_head_req.waddr   = {r_tag, r_k - ORD_W'(1)};
                w_head_wdata.has   = 1'b1;
                w_head_wdata.first = r_p + w_half;
                n_k                = r_k - ORD_W'(1);
                n_state            = (r_k - ORD_W'(1) > r_ord) ? S_SP_RH : S_PO_RH;
            end

            // final pop of the granted block
            S_PO_RH: begin
                w_head_req.re    = 1'b1;
                w_head_req.raddr = {r_tag, r_ord};
                n_state          = S_PO_RN;
            end
            S_PO_RN: begin
                n_p              = w_hd.first;
                w_node_req.re    = 1'b1;
                w_node_req.raddr = w_hd.first;
                n_state          = S_PO_WR;
            end
            S_PO_WR: begin
                w_head_req.we       = 1'b1;
                w_head_req.waddr    = {r_tag, r_ord};
                w_head_wdata.has    = w_nd.linked;
                w_head_wdata.first  = w_nd.linked ? w_nd.next : '0;
                w_node_req.we       = 1'b1;
                w_node_req.waddr    = r_p;
                w_node_wdata        = w_nd;
                w_node_wdata.alloc  = 1'b1;
                w_node_wdata.linked = 1'b0;
                w_node_wdata.next   = '0;
                n_count[r_tag]      = r_count[r_tag] - w_size;
                n_res_frame         = r_p;
                n_res_pages         = w_size[15:0];
                n_state             = S_FIN;
            end

            // free: check the block head, then push it back
            S_FR_CHK: begin
                if (!w_nd.avail || !w_nd.alloc || w_nd.tag >= TAG_W'(DUMMY_TAG)) begin
                    n_status = STAT_BAD;
                    n_state  = S_FIN;
                end else begin
                    n_tag            = w_nd.tag;
                    n_ord            = w_nd.order;
                    n_pfn            = r_frame;
                    n_prev_node      = w_nd;
                    w_head_req.re    = 1'b1;
                    w_head_req.raddr = {w_nd.tag, w_nd.order};
                    n_state          = S_FR_PUSH;
                end
            end
            S_FR_PUSH: begin
                w_node_req.we       = 1'b1;
                w_node_req.waddr    = r_pfn;
                w_node_wdata        = r_prev_node;
                w_node_wdata.alloc  = 1'b0;
                w_node_wdata.linked = w_hd.has;
                w_node_wdata.next   = w_hd.has ? w_hd.first : '0;
                w_head_req.we       = 1'b1;
                w_head_req.waddr    = {r_tag, r_ord};
                w_head_wdata.has    = 1'b1;
                w_head_wdata.first  = r_pfn;
                n_count[r_tag]      = f_sat_add(r_count[r_tag], w_size);
                n_res_pages         = w_size[15:0];
                n_state             = S_MG_CHK;
            end

            // merge with the buddy while it is a free block of the same kind
            S_MG_CHK: begin
                if (r_ord == ORD_W'(MAX_ORDER) || w_other[16]) begin
                    n_state = S_FIN;
                end else begin
                    n_other          = w_other[PFN_W-1:0];
                    w_node_req.re    = 1'b1;
                    w_node_req.raddr = w_other[PFN_W-1:0];
                    n_state          = S_MG_CMP;
                end
            end
            S_MG_CMP: begin
                if (!w_nd.avail || w_nd.alloc || w_nd.tag != r_tag || w_nd.order != r_ord) begin
                    n_state = S_FIN;
                end else begin
                    n_ul_target = r_other;
                    n_ul_second = 1'b0;
                    n_state     = S_UL_HD;
                end
            end

            // unlink the target page from list (tag, ord)
            S_UL_HD: begin
                w_head_req.re    = 1'b1;
                w_head_req.raddr = {r_tag, r_ord};
                n_state          = S_UL_FIRST;
            end
            S_UL_FIRST: begin
                if (!w_hd.has) begin
                    n_state = r_ul_second ? S_MS_RH : S_FIN;
                end else if (w_hd.first == r_ul_target) begin
                    w_node_req.re    = 1'b1;
                    w_node_req.raddr = r_ul_target;
                    n_state          = S_UL_POP;
                end else begin
                    n_prev  = w_hd.first;
                    n_steps = '0;
                    n_state = S_UL_RD;
                end
            end
            S_UL_POP: begin
                w_head_req.we       = 1'b1;
                w_head_req.waddr    = {r_tag, r_ord};
                w_head_wdata.has    = w_nd.linked;
                w_head_wdata.first  = w_nd.linked ? w_nd.next : '0;
                w_node_req.we       = 1'b1;
                w_node_req.waddr    = r_ul_target;
                w_node_wdata        = w_nd;
                w_node_wdata.linked = 1'b0;
                w_node_wdata.next   = '0;
                n_ul_second         = 1'b1;
                n_ul_target         = r_pfn;
                n_state             = r_ul_second ? S_MS_RH : S_UL_HD;
            end
            S_UL_RD: begin
                if (r_steps[16]) begin
                    n_state = r_ul_second ? S_MS_RH : S_FIN;
                end else begin
                    w_node_req.re    = 1'b1;
                    w_node_req.raddr = r_prev;
                    n_state          = S_UL_CHK;
                end
            end
            S_UL_CHK: begin
                n_prev_node = w_nd;
                if (!w_nd.linked) begin
                    n_state = r_ul_second ? S_MS_RH : S_FIN;
                end else if (w_nd.next == r_ul_target) begin
                    w_node_req.re    = 1'b1;
                    w_node_req.raddr = w_nd.next;
                    n_state          = S_UL_LNK;
                end else begin
                    n_prev  = w_nd.next;
                    n_steps = r_steps + 17'd1;
                    n_state = S_UL_RD;
                end
            end
            S_UL_LNK: begin
                w_node_req.we       = 1'b1;
                w_node_req.waddr    = r_prev;
                w_node_wdata        = r_prev_node;
                w_node_wdata.linked = w_nd.linked;
                w_node_wdata.next   = w_nd.next;
                n_state             = S_UL_CLR;
            end
            S_UL_CLR: begin
                w_node_req.we       = 1'b1;
                w_node_req.waddr    = r_ul_target;
                w_node_wdata        = w_nd;
                w_node_wdata.linked = 1'b0;
                w_node_wdata.next   = '0;
                n_ul_second         = 1'b1;
                n_ul_target         = r_pfn;
                n_state             = r_ul_second ? S_MS_RH : S_UL_HD;
            end

            // build the merged block and push it one order up
            S_MS_RH: begin
                w_head_req.re    = 1'b1;
                w_head_req.raddr = {r_tag, r_ord + ORD_W'(1)};
                w_node_req.we    = 1'b1;
                w_node_req.waddr = w_hi_pfn;
                w_node_wdata     = f_block(r_ord + ORD_W'(1), r_tag, 1'b0, '0);
                n_state          = S_MS_WR;
            end
            S_MS_WR: begin
                w_node_req.we      = 1'b1;
                w_node_req.waddr   = w_lo_pfn;
                w_node_wdata       = f_block(r_ord + ORD_W'(1), r_tag, w_hd.has, w_hd.first);
                w_head_req.we      = 1'b1;
                w_head_req.waddr   = {r_tag, r_ord + ORD_W'(1)};
                w_head_wdata.has   = 1'b1;
                w_head_wdata.first = w_lo_pfn;
                n_pfn              = w_lo_pfn;
                n_ord              = r_ord + ORD_W'(1);
                n_state            = S_MG_CHK;
            end

            // add region: carve one aligned block per pass
            S_AD_RH: begin
                if (r_rem == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_k              = w_bord;
                    w_head_req.re    = 1'b1;
                    w_head_req.raddr = {r_tag, w_bord};
                    n_state          = S_AD_WR;
                end
            end
            S_AD_WR: begin
                w_node_req.we      = 1'b1;
                w_node_req.waddr   = r_cur[PFN_W-1:0];
                w_node_wdata       = f_block(r_k, r_tag, w_hd.has, w_hd.first);
                w_head_req.we      = 1'b1;
                w_head_req.waddr   = {r_tag, r_k};
                w_head_wdata.has   = 1'b1;
                w_head_wdata.first = r_cur[PFN_W-1:0];
                n_cur              = r_cur + (17'd1 << r_k);
                n_rem              = r_rem - (17'd1 << r_k);
                n_state            = S_AD_RH;
            end

            // hand the result to the output register
            S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_frame  = (r_status == STAT_OK) ? r_res_frame : '0;
                    n_out_pages  = (r_status == STAT_OK) ? r_res_pages : '0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            for (int t = 0; t < TAG_COUNT; t++) begin
                r_count[t] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_req        <= n_req;
        r_frame      <= n_frame;
        r_len        <= n_len;
        r_tag        <= n_tag;
        r_ord        <= n_ord;
        r_k          <= n_k;
        r_pfn        <= n_pfn;
        r_other      <= n_other;
        r_p          <= n_p;
        r_ul_target  <= n_ul_target;
        r_ul_second  <= n_ul_second;
        r_prev       <= n_prev;
        r_prev_node  <= n_prev_node;
        r_steps      <= n_steps;
        r_cur        <= n_cur;
        r_rem        <= n_rem;
        r_status     <= n_status;
        r_res_frame  <= n_res_frame;
        r_res_pages  <= n_res_pages;
        r_out_status <= n_out_status;
        r_out_frame  <= n_out_frame;
        r_out_pages  <= n_out_pages;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_block_frame = r_out_frame;
    assign o_block_pages = r_out_pages;

`ifndef NO_ASSERTIONS
    // the sweep starts right after reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (r_state == S_CLR))
        else $error("node sweep did not start after reset");

    // a granted block never drives its tag's free count below zero
    a_count_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PO_WR) |-> (r_count[r_tag] >= w_size))
        else $error("free page count underflow on allocate");

    // a finished command lands in the output register once the slot frees
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !(r_out_valid && i_stall)) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not loaded");

    // failures carry no frame and no page count
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != STAT_OK) |-> (o_block_frame == '0 && o_block_pages == '0))
        else $error("failed transaction carries data");
`endif

endmodule

FILE: verif/buddy_page_allocator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator_checker
// Watches the command and result channels of the buddy page allocator, keeps
// its own copy of the page nodes, free lists and per-tag free counts, works
// out the answer to each accepted command and compares it with the result.
// ----------------------------------------------------------------------------
module buddy_page_allocator_checker
    import bpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_cmd_stall,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_page_request,
    input  logic [15:0] i_frame_number,
    input  logic [16:0] i_region_pages,
    input  logic [3:0]  i_zone_tag,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [1:0]  i_status,
    input  logic [15:0] i_block_frame,
    input  logic [15:0] i_block_pages,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);

    typedef struct {
        t_status     status;
        logic [15:0] frame;
        logic [15:0] pages;
    } t_answer;

    // shadow allocator state
    t_node       pages_tbl [NUM_PAGES];
    t_head       heads_tbl [TAG_COUNT][ORDER_SLOTS];
    int unsigned free_cnt  [TAG_COUNT];
    t_answer     answers_q [$];

    function automatic void list_push(int unsigned pfn, int unsigned tag, int unsigned ord);
        pages_tbl[pfn].linked = heads_tbl[tag][ord].has;
        pages_tbl[pfn].next   = heads_tbl[tag][ord].has ? heads_tbl[tag][ord].first : '0;
        heads_tbl[tag][ord].has   = 1'b1;
        heads_tbl[tag][ord].first = pfn[15:0];
    endfunction

    function automatic int unsigned list_pop(int unsigned tag, int unsigned ord);
        int unsigned pfn;
        pfn = heads_tbl[tag][ord].first;
        heads_tbl[tag][ord].has   = pages_tbl[pfn].linked;
        heads_tbl[tag][ord].first = pages_tbl[pfn].linked ? pages_tbl[pfn].next : '0;
        pages_tbl[pfn].linked = 1'b0;
        pages_tbl[pfn].next   = '0;
        return pfn;
    endfunction

    function automatic bit list_unlink(int unsigned pfn, int unsigned tag, int unsigned ord);
        int unsigned prev, cur, steps;
        if (!heads_tbl[tag][ord].has) return 0;
        if (heads_tbl[tag][ord].first == pfn) begin
            void'(list_pop(tag, ord));
            return 1;
        end
        prev = heads_tbl[tag][ord].first;
        for (steps = 0; steps < NUM_PAGES && pages_tbl[prev].linked; steps++) begin
            cur = pages_tbl[prev].next;
            if (cur == pfn) begin
                pages_tbl[prev].linked = pages_tbl[cur].linked;
                pages_tbl[prev].next   = pages_tbl[cur].next;
                pages_tbl[cur].linked  = 1'b0;
                pages_tbl[cur].next    = '0;
                return 1;
            end
            prev = cur;
        end
        return 0;
    endfunction

    function automatic void mark_block(int unsigned pfn, int unsigned tag, int unsigned ord);
        pages_tbl[pfn].order  = ord[3:0];
        pages_tbl[pfn].tag    = tag[3:0];
        pages_tbl[pfn].alloc  = 1'b0;
        pages_tbl[pfn].avail  = 1'b1;
        pages_tbl[pfn].linked = 1'b0;
        pages_tbl[pfn].next   = '0;
    endfunction

    function automatic void credit(int unsigned tag, int unsigned n);
        free_cnt[tag] = (free_cnt[tag] + n > COUNT_MAX) ? COUNT_MAX : free_cnt[tag] + n;
    endfunction

    // allocate: round up, split down, pop the head
    function automatic t_answer grant_pages(int unsigned cnt, int unsigned tag);
        t_answer a;
        int unsigned ord, j, k, p;
        a = '{STAT_OK, '0, '0};
        ord = 0;
        if (tag >= DUMMY_TAG) begin a.status = STAT_BAD; return a; end
        while (ord <= MAX_ORDER && (1 << ord) < cnt) ord++;
        if (ord > MAX_ORDER) begin a.status = STAT_BAD; return a; end
        if (free_cnt[tag] < (1 << ord) || ord == MAX_ORDER) begin
            a.status = STAT_NOSPACE;
            return a;
        end
        j = ord;
        while (j <= MAX_ORDER && !heads_tbl[tag][j].has) j++;
        if (j > MAX_ORDER) begin a.status = STAT_NOSPACE; return a; end
        for (k = j; k > ord; k--) begin
            p = list_pop(tag, k);
            mark_block(p, tag, k - 1);
            mark_block(p + (1 << (k - 1)), tag, k - 1);
            list_push(p, tag, k - 1);
            list_push(p + (1 << (k - 1)), tag, k - 1);
        end
        p = list_pop(tag, ord);
        pages_tbl[p].alloc = 1'b1;
        free_cnt[tag] -= (1 << ord);
        a.frame = p[15:0];
        a.pages = 16'(1 << ord);
        return a;
    endfunction

    // free: push back, then merge with the buddy while it is free
    function automatic t_answer release_block(int unsigned pfn);
        t_answer a;
        int unsigned tag, ord, sz, other, head;
        a = '{STAT_OK, '0, '0};
        tag = pages_tbl[pfn].tag;
        ord = pages_tbl[pfn].order;
        if (!pages_tbl[pfn].avail || !pages_tbl[pfn].alloc || tag >= DUMMY_TAG) begin
            a.status = STAT_BAD;
            return a;
        end
        pages_tbl[pfn].alloc = 1'b0;
        list_push(pfn, tag, ord);
        credit(tag, 1 << ord);
        a.pages = 16'(1 << ord);
        while (ord < MAX_ORDER) begin
            sz = 1 << ord;
            other = ((pfn & (2 * sz - 1)) == 0) ? pfn + sz : pfn - sz;
            if (other >= NUM_PAGES) break;
            if (!pages_tbl[other].avail || pages_tbl[other].alloc ||
                pages_tbl[other].tag != tag || pages_tbl[other].order != ord) break;
            if (!list_unlink(other, tag, ord)) break;
            void'(list_unlink(pfn, tag, ord));
            head = (other < pfn) ? other : pfn;
            mark_block(pfn, tag, ord + 1);
            mark_block(other, tag, ord + 1);
            list_push(head, tag, ord + 1);
            pfn = head;
            ord++;
        end
        return a;
    endfunction

    // add region: carve into aligned power-of-two blocks
    function automatic t_answer carve_region(int unsigned start, int unsigned len,
                                             int unsigned tag);
        t_answer a;
        int unsigned cur, stop, ord;
        a = '{STAT_OK, '0, '0};
        stop = start + len;
        if (tag >= DUMMY_TAG || stop > NUM_PAGES) begin a.status = STAT_BAD; return a; end
        credit(tag, len);
        cur = start;
        while (cur < stop) begin
            ord = MAX_ORDER;
            while (ord > 0 && ((cur & ((1 << ord) - 1)) != 0 || cur + (1 << ord) > stop))
                ord--;
            mark_block(cur, tag, ord);
            list_push(cur, tag, ord);
            cur += (1 << ord);
        end
        return a;
    endfunction

    initial begin
        foreach (pages_tbl[i]) pages_tbl[i] = NODE_RESET;
        foreach (heads_tbl[t, o]) heads_tbl[t][o] = '0;
        foreach (free_cnt[t]) free_cnt[t] = 0;
        o_fail_count   = 0;
        o_result_count = 0;
        o_pending      = 0;
    end

    // predict on accepted commands, compare accepted results
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && i_valid && !i_cmd_stall) begin
            case (i_command)
                CMD_ALLOC: want = grant_pages(i_page_request, i_zone_tag);
                CMD_FREE:  want = release_block(i_frame_number);
                CMD_ADD:   want = carve_region(i_frame_number, i_region_pages, i_zone_tag);
                default:   want = '{STAT_BAD, '0, '0};
            endcase
            answers_q.push_back(want);
        end
        if (i_rst_n && i_res_valid && !i_res_stall) begin
            o_result_count++;
            if (answers_q.size() == 0) begin
                $error("unexpected result transaction: status %0d", i_status);
                o_fail_count++;
            end else begin
                want = answers_q.pop_front();
                if (i_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, i_status);
                    o_fail_count++;
                end
                if (i_block_frame !== want.frame) begin
                    $error("block_frame: expected %0d, got %0d", want.frame, i_block_frame);
                    o_fail_count++;
                end
                if (i_block_pages !== want.pages) begin
                    $error("block_pages: expected %0d, got %0d", want.pages, i_block_pages);
                    o_fail_count++;
                end
            end
        end
        o_pending = answers_q.size();
    end

endmodule

FILE: verif/buddy_page_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator_test
// Drives directed and random allocate, free and add-region commands with
// bursty input and a stalling receiver; a checker module predicts results.
// ----------------------------------------------------------------------------
module buddy_page_allocator_test;
    import bpa_pkg::*;

    localparam int IDLE_LIMIT = 400000;  // covers the post-reset node sweep

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    logic [1:0]  command = '0;
    logic [15:0] page_request = '0;
    logic [15:0] frame_number = '0;
    logic [16:0] region_pages = '0;
    logic [3:0]  zone_tag = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [1:0]  status;
    logic [15:0] block_frame, block_pages;
    int          fail_count, pending, result_count;
    int          sent = 0;
    int          idle_cycles = 0;
    logic [15:0] held_frames [$];

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    buddy_page_allocator dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(cmd_valid), .o_stall(cmd_stall),
        .i_command(command), .i_page_request(page_request),
        .i_frame_number(frame_number), .i_region_pages(region_pages),
        .i_zone_tag(zone_tag),
        .o_valid(res_valid), .i_stall(res_stall),
        .o_status(status), .o_block_frame(block_frame), .o_block_pages(block_pages)
    );

    buddy_page_allocator_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(cmd_valid), .i_cmd_stall(cmd_stall),
        .i_command(command), .i_page_request(page_request),
        .i_frame_number(frame_number), .i_region_pages(region_pages),
        .i_zone_tag(zone_tag),
        .i_res_valid(res_valid), .i_res_stall(res_stall),
        .i_status(status), .i_block_frame(block_frame), .i_block_pages(block_pages),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    // receiver stall pattern: sparse random stalls
    always @(negedge clk) begin
        if (($urandom_range(0, 511) < 256))
            res_stall <= 1'b0;
        else
            res_stall <= ($urandom_range(0, 3) == 0);
    end

    // watchdog on accepted transactions
    always @(posedge clk) begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("buddy_page_allocator_test: FAIL");
            $finish;
        end
    end

    // present one command transaction and hold it until accepted
    task automatic issue(logic [1:0] cmd, logic [15:0] req, logic [15:0] frm,
                         logic [16:0] len, logic [3:0] tag);
        cmd_valid    <= 1'b1;
        command      <= cmd;
        page_request <= req;
        frame_number <= frm;
        region_pages <= len;
        zone_tag     <= tag;
        do @(posedge clk); while (cmd_stall);
        @(negedge clk);
        sent++;
    endtask

    task automatic pause_sender();
        cmd_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
    endtask

    // random command, mostly well-formed
    task automatic random_command();
        int unsigned pick, ord;
        logic [15:0] frm;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            ord = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 5);
            issue(CMD_ALLOC, 16'($urandom_range(1 << ord >> 1, 1 << ord)), 16'($urandom),
                  17'($urandom), 4'($urandom_range(0, 3)));
        end else if (pick < 85 && held_frames.size() > 0) begin
            frm = held_frames[$urandom_range(0, held_frames.size() - 1)];
            issue(CMD_FREE, 16'($urandom), frm, 17'($urandom), 4'($urandom));
        end else if (pick < 92) begin
            frm = 16'($urandom_range(0, 65535));
            issue(CMD_ADD, 16'($urandom), frm, 17'($urandom_range(0, 65536 - frm) >> 4),
                  4'($urandom_range(0, 15)));
        end else begin
            issue(2'($urandom), 16'($urandom), 16'($urandom), 17'($urandom),
                  4'($urandom));
        end
    endtask

    // record granted frames so frees hit real blocks
    always @(posedge clk)
        if (res_valid && !res_stall && status == STAT_OK && block_frame != 0 &&
            held_frames.size() < 64)
            held_frames.push_back(block_frame);

    initial begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: regions, extremes, every command and error case
        issue(CMD_ADD,   16'd0,     16'd0,     17'd4096,  4'd0);
        issue(CMD_ADD,   16'd0,     16'd4099,  17'd333,   4'd1);
        issue(CMD_ADD,   16'd0,     16'd8192,  17'd0,     4'd2);
        issue(CMD_ADD,   16'd0,     16'd65535, 17'd2,     4'd2);
        issue(CMD_ADD,   16'd0,     16'd100,   17'd10,    4'(DUMMY_TAG));
        issue(CMD_ADD,   16'd0,     16'd32768, 17'd32768, 4'd3);
        issue(CMD_ALLOC, 16'd0,     16'd0,     17'd0,     4'd0);
        issue(CMD_ALLOC, 16'd1,     16'd0,     17'd0,     4'd0);
        issue(CMD_ALLOC, 16'd3,     16'd0,     17'd0,     4'd1);
        issue(CMD_ALLOC, 16'd32768, 16'd0,     17'd0,     4'd3);
        issue(CMD_ALLOC, 16'd65535, 16'd0,     17'd0,     4'd3);
        issue(CMD_ALLOC, 16'd2048,  16'd0,     17'd0,     4'd3);
        issue(CMD_ALLOC, 16'd16,    16'd0,     17'd0,     4'd14);
        issue(CMD_ALLOC, 16'd1,     16'd0,     17'd0,     4'hF);
        issue(CMD_ALLOC, 16'd256,   16'd0,     17'd0,     4'd1);
        issue(CMD_FREE,  16'd0,     16'd0,     17'd0,     4'd0);
        issue(CMD_FREE,  16'd0,     16'd1,     17'd0,     4'd0);
        issue(CMD_FREE,  16'd0,     16'd1,     17'd0,     4'd0);
        issue(CMD_FREE,  16'd0,     16'd65535, 17'd0,     4'd0);
        issue(CMD_ADD,   16'd0,     16'd0,     17'd1024,  4'd0);
        issue(CMD_ADD,   16'd0,     16'd40000, 17'd30000, 4'd4);
        issue(2'd3,      16'hFFFF,  16'hFFFF,  17'h1FFFF, 4'hF);
        issue(CMD_ADD,   16'd0,     16'd0,     17'd65536, 4'd5);
        issue(CMD_ADD,   16'd0,     16'd0,     17'd65536, 4'd5);

        // random part in bursts
        while (sent < 900) begin
            repeat ($urandom_range(1, 20)) random_command();
            if ($urandom_range(0, 2) != 0) pause_sender();
            if (held_frames.size() > 0 && $urandom_range(0, 1) == 0)
                void'(held_frames.pop_front());
        end
        cmd_valid <= 1'b0;

        // drain, then allow for the last command's tail
        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);

        $display("Sent %0d command transactions; %0d results checked.", sent, result_count);
        if (fail_count == 0)
            $display("buddy_page_allocator_test: PASS");
        else
            $display("buddy_page_allocator_test: FAIL");
        $finish;
    end

endmodule
